// ----- rtl/core/rrid_pkg.sv -----
// Shared types and constants for the run-length image decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rrid_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [3:0]  HDR_LAST_IDX = 4'd9;
	localparam logic [3:0]  HDR_WIDTH_END = 4'd2;
	localparam logic [3:0]  HDR_HEIGHT_END = 4'd4;
	localparam logic [3:0]  HDR_DEPTH_START = 4'd8;
	localparam logic [15:0] DEPTH_COLOR = 16'd24;
	localparam logic [15:0] DEPTH_GRAY = 16'd8;
	localparam logic [1:0]  NEED_COLOR = 2'd3;
	localparam logic [1:0]  NEED_GRAY = 2'd1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_COUNT,
		PH_PIXEL,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT_HEADER,
		ST_BAD_DEPTH,
		ST_ZERO_SIZE,
		ST_BAD_RUN,
		ST_EXTRA_ROWS,
		ST_INCOMPLETE
	} status_t;

	typedef struct packed {
		logic        run_valid;
		logic [23:0] pixel_value;
		logic [7:0]  run_length;
		logic [15:0] row;
		logic [15:0] column;
		logic        color_mode;
		logic        frame_done;
		logic [2:0]  status;
	} result_t;

endpackage

// ----- rtl/core/rrid_parser.sv -----
// Front end: header parse, run classification and result build, one byte a beat.
// Depends on rrid_pkg.
`timescale 1ns / 1ps

module rrid_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              push,
	output rrid_pkg::result_t result
);

	logic [3:0]             hidx_q, hidx_n;
	logic [15:0]            width_q, width_n;
	logic [15:0]            height_q, height_n;
	logic [15:0]            depth_q, depth_n;
	logic [16:0]            col_q, col_n;
	logic [16:0]            row_q, row_n;
	logic [7:0]             pend_q, pend_n;
	logic [23:0]            acc_q, acc_n;
	logic [1:0]             seen_q, seen_n;
	rrid_pkg::phase_t       phase_q, phase_n;
	rrid_pkg::status_t      err_q, err_n;
	logic                   run;
	logic                   short_hdr;
	logic                   wrapped;
	logic [23:0]            emit_pix;
	logic [1:0]             need;
	logic [17:0]            run_end;
	logic [16:0]            row_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			depth_q  <= '0;
			col_q    <= '0;
			row_q    <= 17'd1;
			pend_q   <= '0;
			acc_q    <= '0;
			seen_q   <= '0;
			phase_q  <= rrid_pkg::PH_HEADER;
			err_q    <= rrid_pkg::ST_OK;
		end else begin
			hidx_q   <= hidx_n;
			width_q  <= width_n;
			height_q <= height_n;
			depth_q  <= depth_n;
			col_q    <= col_n;
			row_q    <= row_n;
			pend_q   <= pend_n;
			acc_q    <= acc_n;
			seen_q   <= seen_n;
			phase_q  <= phase_n;
			err_q    <= err_n;
		end
	end

	always_comb begin
		hidx_n    = hidx_q;
		width_n   = width_q;
		height_n  = height_q;
		depth_n   = depth_q;
		col_n     = col_q;
		row_n     = row_q;
		pend_n    = pend_q;
		acc_n     = acc_q;
		seen_n    = seen_q;
		phase_n   = phase_q;
		err_n     = err_q;
		run       = 1'b0;
		short_hdr = 1'b0;
		wrapped   = 1'b0;
		emit_pix  = '0;
		need      = (depth_q == rrid_pkg::DEPTH_COLOR) ? rrid_pkg::NEED_COLOR
		                                              : rrid_pkg::NEED_GRAY;
		run_end   = '0;
		row_m1    = '0;
		result    = '0;

		if (accept) begin
			unique case (phase_q)
				rrid_pkg::PH_HEADER: begin
					if (hidx_q < rrid_pkg::HDR_WIDTH_END)
						width_n = {width_q[7:0], data_byte};
					else if (hidx_q < rrid_pkg::HDR_HEIGHT_END)
						height_n = {height_q[7:0], data_byte};
					else if (hidx_q >= rrid_pkg::HDR_DEPTH_START)
						depth_n = {depth_q[7:0], data_byte};
					if (hidx_q >= rrid_pkg::HDR_LAST_IDX) begin
						if (depth_n != rrid_pkg::DEPTH_COLOR && depth_n != rrid_pkg::DEPTH_GRAY) begin
							err_n   = rrid_pkg::ST_BAD_DEPTH;
							phase_n = rrid_pkg::PH_DRAIN;
						end else if (width_n == '0 || height_n == '0) begin
							err_n   = rrid_pkg::ST_ZERO_SIZE;
							phase_n = rrid_pkg::PH_DRAIN;
						end else begin
							phase_n = rrid_pkg::PH_COUNT;
						end
					end else begin
						hidx_n    = hidx_q + 4'd1;
						short_hdr = last_byte;
					end
				end
				rrid_pkg::PH_COUNT: begin
					if (col_q == {1'b0, width_q}) begin
						col_n   = '0;
						row_n   = row_q + 17'd1;
						wrapped = 1'b1;
					end
					run_end = {1'b0, col_n} + {10'd0, data_byte};
					if (wrapped && row_n > {1'b0, height_q}) begin
						err_n   = rrid_pkg::ST_EXTRA_ROWS;
						phase_n = rrid_pkg::PH_DRAIN;
					end else if (data_byte == '0 || run_end > {2'b0, width_q}) begin
						err_n   = rrid_pkg::ST_BAD_RUN;
						phase_n = rrid_pkg::PH_DRAIN;
					end else begin
						pend_n  = data_byte;
						acc_n   = '0;
						seen_n  = '0;
						phase_n = rrid_pkg::PH_PIXEL;
						run     = last_byte;
					end
				end
				rrid_pkg::PH_PIXEL: begin
					acc_n  = {acc_q[15:0], data_byte};
					seen_n = seen_q + 2'd1;
					if (seen_n >= need) begin
						run      = 1'b1;
						emit_pix = acc_n;
						phase_n  = rrid_pkg::PH_COUNT;
					end else begin
						run = last_byte;
					end
				end
				rrid_pkg::PH_DRAIN: begin
				end
			endcase

			if (run) begin
				row_m1             = row_n - 17'd1;
				result.run_valid   = 1'b1;
				result.pixel_value = emit_pix;
				result.run_length  = pend_n;
				result.row         = row_m1[15:0];
				result.column      = col_n[15:0];
				result.color_mode  = (depth_n == rrid_pkg::DEPTH_COLOR);
				col_n              = col_n + {9'd0, pend_n};
			end

			if (last_byte) begin
				result.frame_done = 1'b1;
				if (short_hdr)
					result.status = rrid_pkg::ST_SHORT_HEADER;
				else if (err_n != rrid_pkg::ST_OK)
					result.status = err_n;
				else if (col_n != {1'b0, width_n} || row_n != {1'b0, height_n})
					result.status = rrid_pkg::ST_INCOMPLETE;
				else
					result.status = rrid_pkg::ST_OK;
				hidx_n   = '0;
				width_n  = '0;
				height_n = '0;
				depth_n  = '0;
				col_n    = '0;
				row_n    = 17'd1;
				pend_n   = '0;
				acc_n    = '0;
				seen_n   = '0;
				phase_n  = rrid_pkg::PH_HEADER;
				err_n    = rrid_pkg::ST_OK;
			end
		end
	end

	assign push = accept && (run || last_byte);

endmodule

// ----- rtl/core/rrid_queue.sv -----
// Back end: result queue between the parser and the output channel.
// Depends on rrid_pkg; head entry drives the output ports.
`timescale 1ns / 1ps

module rrid_queue #(
	parameter int unsigned DEPTH = rrid_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rrid_pkg::result_t din,
	input  logic              pop,
	output rrid_pkg::result_t dout,
	output logic              full,
	output logic              empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	rrid_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- rtl/core/rle_run_image_decoder.sv -----
// Top level of the run-length image decoder: parser front end and result queue.
// Depends on rrid_pkg, rrid_parser and rrid_queue.
`timescale 1ns / 1ps

// Takes one packet byte per beat and parses a 10-byte header followed by runs
// (count byte plus 1- or 3-byte pixel). The parser decodes each byte as it is
// accepted, so one byte per clock is sustained while the queue is not full; a
// result (a decoded run, an end-of-frame status, or both) is ready the cycle
// after the byte that completes it. Results wait in a QUEUE_DEPTH-entry queue,
// so input keeps flowing while the output side stalls until the queue fills.
module rle_run_image_decoder #(
	parameter int unsigned QUEUE_DEPTH = rrid_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        run_valid,
	output logic [23:0] pixel_value,
	output logic [7:0]  run_length,
	output logic [15:0] row,
	output logic [15:0] column,
	output logic        color_mode,
	output logic        frame_done,
	output logic [2:0]  status
);

	logic              accept;
	logic              push;
	logic              full;
	logic              empty;
	rrid_pkg::result_t res_new;
	rrid_pkg::result_t res_head;

	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign out_valid = !empty;

	rrid_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.result    (res_new)
	);

	rrid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res_new),
		.pop    (out_valid && out_ready),
		.dout   (res_head),
		.full   (full),
		.empty  (empty)
	);

	assign run_valid   = res_head.run_valid;
	assign pixel_value = res_head.pixel_value;
	assign run_length  = res_head.run_length;
	assign row         = res_head.row;
	assign column      = res_head.column;
	assign color_mode  = res_head.color_mode;
	assign frame_done  = res_head.frame_done;
	assign status      = res_head.status;

	a_no_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_valid || frame_done))
		else $error("result beat carries neither run nor done");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_valid) |->
		(pixel_value == '0 && run_length == '0 && row == '0 && column == '0 && !color_mode))
		else $error("run fields not cleared without a run");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_done ? (status <= 3'd6) : (status == 3'd0)))
		else $error("status out of range or set without done");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("queued result not visible");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for rle_run_image_decoder: drives packet bytes and checks each
// result beat against an in-bench decoder model kept in a small scoreboard class.
// Depends on rrid_pkg and the rle_run_image_decoder RTL.
`timescale 1ns / 1ps

module tb;
	import rrid_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 900;
	localparam int IDLE_PCT = 7;
	localparam int HOLD_CYCLES = 80;

	class rle_checker;
		logic [3:0]  hdr_idx;
		logic [15:0] img_w;
		logic [15:0] img_h;
		logic [15:0] depth;
		logic [16:0] col_pos;
		logic [16:0] row_pos;
		logic [7:0]  run_len;
		logic [23:0] pix_acc;
		logic [1:0]  pix_seen;
		phase_t      phase;
		status_t     err;
		result_t     expected_beats[$];
		int          mismatches;
		int          runs_seen;
		int          frames_seen;
		int          error_frames;

		function new();
			clear_packet();
		endfunction

		function void clear_packet();
			hdr_idx = '0;
			img_w = '0;
			img_h = '0;
			depth = '0;
			col_pos = '0;
			row_pos = 17'd1;
			run_len = '0;
			pix_acc = '0;
			pix_seen = '0;
			phase = PH_HEADER;
			err = ST_OK;
		endfunction

		function void fail_packet(status_t code);
			err = code;
			phase = PH_DRAIN;
		endfunction

		// fills the run fields and moves the column past the run
		function result_t pack_run(logic [23:0] px);
			result_t res;
			res = '0;
			res.run_valid = 1'b1;
			res.pixel_value = px;
			res.run_length = run_len;
			res.row = 16'(row_pos - 17'd1);
			res.column = col_pos[15:0];
			res.color_mode = (depth == DEPTH_COLOR);
			col_pos = col_pos + 17'(run_len);
			return res;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			result_t    res;
			logic       short_hdr;
			logic       got_run;
			logic       row_overflow;
			logic [1:0] need;
			status_t    st;
			res = '0;
			short_hdr = 1'b0;
			got_run = 1'b0;
			row_overflow = 1'b0;
			case (phase)
				PH_HEADER: begin
					if (hdr_idx < HDR_WIDTH_END)
						img_w = {img_w[7:0], b};
					else if (hdr_idx < HDR_HEIGHT_END)
						img_h = {img_h[7:0], b};
					else if (hdr_idx >= HDR_DEPTH_START)
						depth = {depth[7:0], b};
					if (hdr_idx >= HDR_LAST_IDX) begin
						if (depth != DEPTH_COLOR && depth != DEPTH_GRAY)
							fail_packet(ST_BAD_DEPTH);
						else if (img_w == '0 || img_h == '0)
							fail_packet(ST_ZERO_SIZE);
						else
							phase = PH_COUNT;
					end else begin
						hdr_idx++;
						if (last)
							short_hdr = 1'b1;
					end
				end
				PH_COUNT: begin
					if (col_pos == {1'b0, img_w}) begin
						col_pos = '0;
						row_pos++;
						if (row_pos > {1'b0, img_h}) begin
							fail_packet(ST_EXTRA_ROWS);
							row_overflow = 1'b1;
						end
					end
					if (!row_overflow) begin
						if (b == '0 || col_pos + 17'(b) > {1'b0, img_w}) begin
							fail_packet(ST_BAD_RUN);
						end else begin
							run_len = b;
							pix_acc = '0;
							pix_seen = '0;
							phase = PH_PIXEL;
							if (last) begin
								res = pack_run(24'h0);
								got_run = 1'b1;
							end
						end
					end
				end
				PH_PIXEL: begin
					pix_acc = {pix_acc[15:0], b};
					pix_seen++;
					need = (depth == DEPTH_COLOR) ? NEED_COLOR : NEED_GRAY;
					if (pix_seen >= need) begin
						res = pack_run(pix_acc);
						got_run = 1'b1;
						phase = PH_COUNT;
					end else if (last) begin
						res = pack_run(24'h0);
						got_run = 1'b1;
					end
				end
				default: ;
			endcase
			if (last) begin
				if (short_hdr)
					st = ST_SHORT_HEADER;
				else if (err != ST_OK)
					st = err;
				else if (col_pos != {1'b0, img_w} || row_pos != {1'b0, img_h})
					st = ST_INCOMPLETE;
				else
					st = ST_OK;
				res.frame_done = 1'b1;
				res.status = st;
				clear_packet();
				expected_beats.push_back(res);
			end else if (got_run) begin
				expected_beats.push_back(res);
			end
		endfunction

		function string show(result_t r);
			return $sformatf(
				"run=%0d pix=%h len=%0d row=%0d col=%0d color=%0d done=%0d status=%0d",
				r.run_valid, r.pixel_value, r.run_length, r.row, r.column,
				r.color_mode, r.frame_done, r.status);
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result beat with nothing expected: %s", show(got));
				return;
			end
			want = expected_beats.pop_front();
			if (want.run_valid)
				runs_seen++;
			if (want.frame_done) begin
				frames_seen++;
				if (want.status != ST_OK)
					error_frames++;
			end
			if (got.run_valid !== want.run_valid || got.pixel_value !== want.pixel_value ||
					got.run_length !== want.run_length || got.row !== want.row ||
					got.column !== want.column || got.color_mode !== want.color_mode ||
					got.frame_done !== want.frame_done || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result mismatch at %0t", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        run_valid;
	logic [23:0] pixel_value;
	logic [7:0]  run_length;
	logic [15:0] row;
	logic [15:0] column;
	logic        color_mode;
	logic        frame_done;
	logic [2:0]  status;

	rle_checker  board = new();
	logic [7:0]  pkt[$];
	bit          calm = 1'b0;
	bit          hold_start = 1'b0;
	int          hold_left = 0;
	int          bytes_sent = 0;
	int          packets_sent = 0;
	int          cycle_count = 0;

	rle_run_image_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.run_valid(run_valid),
		.pixel_value(pixel_value),
		.run_length(run_length),
		.row(row),
		.column(column),
		.color_mode(color_mode),
		.frame_done(frame_done),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			board.check_beat({run_valid, pixel_value, run_length, row, column,
				color_mode, frame_done, status});
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	function automatic void put_header(int w, int h, int d);
		pkt.push_back(8'(w >> 8));
		pkt.push_back(8'(w));
		pkt.push_back(8'(h >> 8));
		pkt.push_back(8'(h));
		repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
		pkt.push_back(8'(d >> 8));
		pkt.push_back(8'(d));
	endfunction

	function automatic void put_run(int cnt, logic [23:0] px, bit color);
		pkt.push_back(8'(cnt));
		if (color) begin
			pkt.push_back(px[23:16]);
			pkt.push_back(px[15:8]);
		end
		pkt.push_back(px[7:0]);
	endfunction

	// whole image of runs that exactly fills every row
	function automatic void put_image(int w, int h, bit color);
		int col;
		int room;
		int cnt;
		for (int r = 0; r < h; r++) begin
			col = 0;
			while (col < w) begin
				room = (w - col > 255) ? 255 : w - col;
				cnt = ($urandom_range(0, 3) == 0) ? room : $urandom_range(1, room);
				put_run(cnt, 24'($urandom), color);
				col += cnt;
			end
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.take_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		pkt.delete();
		packets_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_beats.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int dir_bytes;
		int kind;
		int w;
		int h;
		int cut;
		bit color;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed packets: header faults, run faults, truncation, extremes
		pkt.push_back(8'hFF);
		send_packet();
		put_header(5, 1, DEPTH_COLOR);
		void'(pkt.pop_back());
		send_packet();
		put_header(4, 1, 16);
		put_run(1, 24'h11, 1'b0);
		send_packet();
		put_header(0, 3, DEPTH_GRAY);
		send_packet();
		put_header(7, 0, DEPTH_COLOR);
		pkt.push_back(8'h00);
		send_packet();
		put_header(3, 2, DEPTH_GRAY);
		put_run(3, 24'h0, 1'b0);
		put_run(1, 24'hFF, 1'b0);
		put_run(2, 24'h5A, 1'b0);
		send_packet();
		put_header(2, 1, DEPTH_COLOR);
		put_run(1, 24'h000000, 1'b1);
		put_run(1, 24'hFFFFFF, 1'b1);
		send_packet();
		put_header(4, 1, DEPTH_GRAY);
		pkt.push_back(8'h00);
		send_packet();
		put_header(4, 1, DEPTH_GRAY);
		pkt.push_back(8'h05);
		send_packet();
		put_header(1, 1, DEPTH_GRAY);
		put_run(1, 24'h07, 1'b0);
		put_run(1, 24'h08, 1'b0);
		send_packet();
		put_header(2, 1, DEPTH_COLOR);
		pkt.push_back(8'h02);
		pkt.push_back(8'hAB);
		send_packet();
		put_header(2, 1, DEPTH_GRAY);
		pkt.push_back(8'h02);
		send_packet();
		put_header(16'hFFFF, 16'hFFFF, DEPTH_COLOR);
		repeat (3) put_run(255, 24'hFFFFFF, 1'b1);
		send_packet();
		put_header(6, 2, DEPTH_GRAY);
		send_packet();
		dir_bytes = bytes_sent;

		for (int n = 0; bytes_sent < dir_bytes + RANDOM_BYTES; n++) begin
			calm = (n == 4) || (n >= 12 && n < 22);
			kind = (n == 4) ? 0 : $urandom_range(0, 99);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
			h = $urandom_range(1, 4);
			color = $urandom_range(0, 1);
			if (n == 4) begin
				// output held off while a dense gray image streams in
				hold_start = 1'b1;
				w = 16;
				h = 3;
				color = 1'b0;
			end
			put_header(w, h, color ? DEPTH_COLOR : DEPTH_GRAY);
			if (n == 4) begin
				repeat (w * h) put_run(1, 24'($urandom), 1'b0);
			end else if (kind < 60) begin
				put_image(w, h, color);
			end else if (kind < 72) begin
				put_image(w, h, color);
				cut = $urandom_range(1, pkt.size());
				while (pkt.size() > cut)
					void'(pkt.pop_back());
			end else if (kind < 82) begin
				put_image(w, h, color);
				pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
			end else if (kind < 90) begin
				put_image(w, h, color);
				put_run($urandom_range(1, 255), 24'($urandom), color);
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom_range(0, 255)));
			end else begin
				pkt.delete();
				repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom_range(0, 255)));
			end
			send_packet();
			if (n == 6)
				wait_drained();
		end
		calm = 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		$display("Covered %0d bytes in %0d packets; checked %0d runs and %0d frame ends %s",
			bytes_sent, packets_sent, board.runs_seen, board.frames_seen,
			$sformatf("(%0d with an error status).", board.error_frames));
		$display("Mismatches: %0d", board.mismatches);
		if (board.mismatches == 0 && board.expected_beats.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
